>>> rtl/core/u8sd_pkg.sv
// Package for the byte-serial UTF-8 stream decoder.
// Holds the request, response and job types and the lead byte helpers.
// No dependencies.
package u8sd_pkg;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;
   localparam int unsigned JOB_SLOTS = 3;

   localparam logic [2:0] LEN_NONE = 3'd0;
   localparam logic [2:0] LEN_ONE = 3'd1;
   localparam logic [2:0] LEN_TWO = 3'd2;
   localparam logic [2:0] LEN_THREE = 3'd3;
   localparam logic [2:0] LEN_FOUR = 3'd4;

   localparam logic [7:0] ASCII_LIMIT = 8'h80;
   localparam logic [2:0] LEAD2_TAG = 3'h6;
   localparam logic [3:0] LEAD3_TAG = 4'hE;
   localparam logic [4:0] LEAD4_TAG = 5'h1E;
   localparam logic [7:0] LEAD2_MASK = 8'h1F;
   localparam logic [7:0] LEAD3_MASK = 8'h0F;
   localparam logic [7:0] LEAD4_MASK = 8'h07;
   localparam logic [7:0] CONT_MASK = 8'h3F;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_buffer;
   } req_type;

   typedef struct packed {
      logic [20:0] code_point;
      logic [2:0]  byte_count;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [20:0] code_point;
      logic [2:0]  byte_count;
   } result_type;

   typedef struct packed {
      logic [1:0]                 num;
      result_type [JOB_SLOTS-1:0] res;
   } job_type;

   function automatic logic [2:0] seq_len(input logic [7:0] c);
      logic [2:0] len;
      len = LEN_ONE;
      if (c < ASCII_LIMIT) begin
         len = LEN_ONE;
      end else if (c[7:5] == LEAD2_TAG) begin
         len = LEN_TWO;
      end else if (c[7:4] == LEAD3_TAG) begin
         len = LEN_THREE;
      end else if (c[7:3] == LEAD4_TAG) begin
         len = LEN_FOUR;
      end
      return len;
   endfunction

   function automatic logic [7:0] lead_bits(input logic [7:0] c, input logic [2:0] len);
      logic [7:0] bits;
      case (len)
         LEN_TWO: begin
            bits = c & LEAD2_MASK;
         end
         LEN_THREE: begin
            bits = c & LEAD3_MASK;
         end
         LEN_FOUR: begin
            bits = c & LEAD4_MASK;
         end
         default: begin
            bits = c;
         end
      endcase
      return bits;
   endfunction

endpackage

>>> rtl/core/u8sd_front.sv
// Front end of the UTF-8 stream decoder: accepts bytes, tracks the open
// sequence and turns each request that yields results into a job of up to three results.
// Depends on u8sd_pkg.
module u8sd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  u8sd_pkg::req_type req_data,
   input  logic              queue_full,
   output logic              push,
   output u8sd_pkg::job_type push_job
);
   import u8sd_pkg::*;

   logic [20:0] partial_ff, partial_in;
   logic [2:0]  expected_ff, expected_in;
   logic [1:0]  seen_ff, seen_in;
   logic [7:0]  held_ff [2];
   logic [7:0]  held_in [2];
   logic        accept;
   logic [7:0]  b;
   logic [2:0]  len;
   logic [2:0]  h1_len;
   logic [20:0] merged;
   job_type     job;

   assign req_ready = !queue_full;
   assign accept = req_valid && req_ready;
   assign b = req_data.in_byte;
   assign len = seq_len(b);
   assign h1_len = seq_len(held_ff[1]);
   assign merged = {partial_ff[14:0], b[5:0]};

   always_comb begin
      partial_in = partial_ff;
      expected_in = expected_ff;
      seen_in = seen_ff;
      held_in = held_ff;
      job = '0;
      if (expected_ff == LEN_NONE) begin
         if (len == LEN_ONE || req_data.end_of_buffer) begin
            job.num = 2'd1;
            job.res[0] = '{code_point: {13'd0, b}, byte_count: LEN_ONE};
         end else begin
            held_in[0] = b;
            seen_in = 2'd1;
            expected_in = len;
            partial_in = {13'd0, lead_bits(b, len)};
         end
      end else if (({1'b0, seen_ff} + 3'd1) >= expected_ff) begin
         job.num = 2'd1;
         job.res[0] = '{code_point: merged, byte_count: expected_ff};
         expected_in = LEN_NONE;
         seen_in = 2'd0;
         partial_in = '0;
      end else if (req_data.end_of_buffer) begin
         job.res[0] = '{code_point: {13'd0, held_ff[0]}, byte_count: LEN_ONE};
         if (seen_ff == 2'd1) begin
            job.num = 2'd2;
            job.res[1] = '{code_point: {13'd0, b}, byte_count: LEN_ONE};
         end else if (h1_len == LEN_TWO) begin
            job.num = 2'd2;
            job.res[1] = '{code_point: {10'd0, held_ff[1][4:0], b[5:0]},
                           byte_count: LEN_TWO};
         end else begin
            job.num = 2'd3;
            job.res[1] = '{code_point: {13'd0, held_ff[1]}, byte_count: LEN_ONE};
            job.res[2] = '{code_point: {13'd0, b}, byte_count: LEN_ONE};
         end
         expected_in = LEN_NONE;
         seen_in = 2'd0;
         partial_in = '0;
      end else begin
         if (seen_ff == 2'd1) begin
            held_in[1] = b;
         end
         seen_in = seen_ff + 2'd1;
         partial_in = merged;
      end
   end

   assign push = accept && (job.num != 2'd0);
   assign push_job = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         expected_ff <= LEN_NONE;
         seen_ff <= '0;
      end else if (accept) begin
         partial_ff <= partial_in;
         expected_ff <= expected_in;
         seen_ff <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

endmodule

>>> rtl/core/u8sd_queue.sv
// Job queue between the front and back ends of the UTF-8 stream decoder.
// Depends on u8sd_pkg.
module u8sd_queue #(
   parameter int unsigned Depth = u8sd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  u8sd_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output u8sd_pkg::job_type head_job
);
   import u8sd_pkg::*;

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);

   job_type         entries_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_pop;

   assign full = (count_ff == CntW'(Depth));
   assign head_valid = (count_ff != '0);
   assign head_job = entries_ff[rd_ptr_ff];
   assign do_pop = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth))
      else $error("Job queue count exceeds its depth.");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("Job pushed into a full queue.");
   a_job_not_empty: assert property (@(posedge clock) disable iff (reset)
      push |-> (push_job.num != 2'd0))
      else $error("Job without results pushed into the queue.");
   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("Queue count did not follow a push.");
`endif

endmodule

>>> rtl/core/u8sd_back.sv
// Back end of the UTF-8 stream decoder: walks the results of the head job
// and presents them one at a time through a registered output stage.
// Depends on u8sd_pkg.
module u8sd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  u8sd_pkg::job_type head_job,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output u8sd_pkg::rsp_type rsp_data
);
   import u8sd_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;
   logic       load;
   logic       last;
   result_type cur;

   assign load = head_valid && (!rsp_valid_ff || rsp_ready);
   assign last = ((idx_ff + 2'd1) == head_job.num);
   assign cur = head_job.res[idx_ff];
   assign pop = load && last;

   always_comb begin
      idx_in = idx_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in = '{code_point: cur.code_point, byte_count: cur.byte_count,
                         last_of_run: last};
         idx_in = last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

>>> rtl/core/utf8_stream_decoder.sv
// Top level of the byte-serial UTF-8 stream decoder.
// Instantiates u8sd_front, u8sd_queue and u8sd_back; depends on u8sd_pkg.
//
//   channel   direction  payload    handshake
//   req_      in         req_type   req_valid / req_ready
//   rsp_      out        rsp_type   rsp_valid / rsp_ready
//
// A request is taken in every cycle while the job queue has room.
// Each request gives zero to three responses, one per cycle while rsp_ready is high, so a buffer
// that ends inside a sequence gives up to three responses.
// The first response of a request passes through the job queue and then the registered output stage.
// Reset is synchronous and leaves no sequence open and the queue empty.
module utf8_stream_decoder #(
   parameter int unsigned QueueDepth = u8sd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  u8sd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output u8sd_pkg::rsp_type rsp_data
);
   import u8sd_pkg::*;

   logic    queue_full;
   logic    push;
   job_type push_job;
   logic    pop;
   logic    head_valid;
   job_type head_job;

   u8sd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   u8sd_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   u8sd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

>>> tb/utf8_decode_checker.sv
`timescale 1ns / 100ps
// Checker for the UTF-8 stream decoder: watches the request and response channels,
// predicts the code points of every accepted request and compares them in order.
// Depends on u8sd_pkg for the request and response types.

module utf8_decode_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  u8sd_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  u8sd_pkg::rsp_type rsp_data,
   output int unsigned       pending_count,
   output int unsigned       fail_count
);

   u8sd_pkg::rsp_type expected_points[$];
   int unsigned       errors = 0;
   int                open_len = 0;
   int                seen_count = 0;
   logic [20:0]       partial_cp = '0;
   logic [7:0]        held[3];

   function automatic int lead_length(input logic [7:0] c);
      if (c < 8'h80) return 1;
      if (c[7:5] == 3'b110) return 2;
      if (c[7:4] == 4'b1110) return 3;
      if (c[7:3] == 5'b11110) return 4;
      return 1;
   endfunction

   function automatic logic [20:0] lead_payload(input logic [7:0] c, input int len);
      case (len)
         2: begin
            return {16'd0, c[4:0]};
         end
         3: begin
            return {17'd0, c[3:0]};
         end
         4: begin
            return {18'd0, c[2:0]};
         end
         default: begin
            return {13'd0, c};
         end
      endcase
   endfunction

   function automatic u8sd_pkg::rsp_type make_point(input logic [20:0] cp, input int cnt);
      u8sd_pkg::rsp_type p;
      p.code_point = cp;
      p.byte_count = 3'(cnt);
      p.last_of_run = 1'b0;
      return p;
   endfunction

   task automatic decode_request(input u8sd_pkg::req_type r);
      u8sd_pkg::rsp_type run[3];
      logic [7:0]        tail[3];
      logic [20:0]       merged;
      logic [20:0]       value;
      int                n;
      int                tail_len;
      int                i;
      int                len;
      n = 0;
      if (open_len == 0) begin
         len = lead_length(r.in_byte);
         if (len == 1 || r.end_of_buffer) begin
            run[n] = make_point({13'd0, r.in_byte}, 1);
            n++;
         end else begin
            held[0] = r.in_byte;
            seen_count = 1;
            open_len = len;
            partial_cp = lead_payload(r.in_byte, len);
         end
      end else begin
         merged = {partial_cp[14:0], r.in_byte[5:0]};
         if (seen_count + 1 >= open_len) begin
            run[n] = make_point(merged, open_len);
            n++;
            open_len = 0;
            seen_count = 0;
            partial_cp = '0;
         end else if (r.end_of_buffer) begin
            // The tail is decoded again from its first byte, so the open lead is emitted raw.
            for (i = 0; i < seen_count; i++) begin
               tail[i] = held[i];
            end
            tail[seen_count] = r.in_byte;
            tail_len = seen_count + 1;
            i = 0;
            while (i < tail_len && n < 3) begin
               len = lead_length(tail[i]);
               if (len > tail_len - i) begin
                  run[n] = make_point({13'd0, tail[i]}, 1);
                  i++;
               end else begin
                  value = lead_payload(tail[i], len);
                  for (int j = 1; j < len; j++) begin
                     value = {value[14:0], tail[i + j][5:0]};
                  end
                  run[n] = make_point(value, len);
                  i += len;
               end
               n++;
            end
            open_len = 0;
            seen_count = 0;
            partial_cp = '0;
         end else begin
            held[seen_count] = r.in_byte;
            seen_count++;
            partial_cp = merged;
         end
      end
      for (i = 0; i < n; i++) begin
         if (i == n - 1) begin
            run[i].last_of_run = 1'b1;
         end
         expected_points.push_back(run[i]);
      end
   endtask

   always @(posedge clock) begin : watch
      u8sd_pkg::rsp_type want;
      if (reset) begin
         expected_points.delete();
         open_len = 0;
         seen_count = 0;
         partial_cp = '0;
      end else begin
         if (req_valid && req_ready) begin
            decode_request(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_points.size() == 0) begin
               errors++;
               $display("%0t: expected no response, actual %h", $time, rsp_data);
            end else begin
               want = expected_points.pop_front();
               if (rsp_data.code_point !== want.code_point) begin
                  errors++;
                  $display("%0t: code_point expected %h, actual %h", $time,
                           want.code_point, rsp_data.code_point);
               end
               if (rsp_data.byte_count !== want.byte_count) begin
                  errors++;
                  $display("%0t: byte_count expected %0d, actual %0d", $time,
                           want.byte_count, rsp_data.byte_count);
               end
               if (rsp_data.last_of_run !== want.last_of_run) begin
                  errors++;
                  $display("%0t: last_of_run expected %b, actual %b", $time,
                           want.last_of_run, rsp_data.last_of_run);
               end
            end
         end
      end
      pending_count <= expected_points.size();
      fail_count <= errors;
   end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// Top of the UTF-8 stream decoder testbench: clock, reset, request stimulus and the verdict.
// Depends on u8sd_pkg, utf8_stream_decoder and utf8_decode_checker.

module testbench;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   u8sd_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   u8sd_pkg::rsp_type rsp_data;
   int unsigned       pending_count;
   int unsigned       fail_count;
   int unsigned       items_sent;
   int                send_idle;
   int                recv_idle;
   logic              hold_off;

   // Bit 8 marks the end of the buffer.
   logic [8:0] directed[25] = '{
      9'h000, 9'h07F, 9'h080, 9'h0FF, 9'h0F8,
      9'h0C0, 9'h080,
      9'h0DF, 9'h1BF,
      9'h0E2, 9'h082, 9'h0AC,
      9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,
      9'h0F0, 9'h0C3, 9'h1A9,
      9'h1C3,
      9'h0F4, 9'h08F, 9'h1BF,
      9'h0E2, 9'h182
   };

   utf8_stream_decoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   utf8_decode_checker decode_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .pending_count (pending_count),
      .fail_count    (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("utf8_stream_decoder regression: fail");
      $finish;
   end

   function automatic logic [7:0] random_lead(input int len);
      logic [7:0] lead;
      case (len)
         2: begin
            lead = 8'hC0 + 8'($urandom_range(31));
         end
         3: begin
            lead = 8'hE0 + 8'($urandom_range(15));
         end
         default: begin
            lead = 8'hF0 + 8'($urandom_range(7));
         end
      endcase
      return lead;
   endfunction

   function automatic logic [7:0] random_cont();
      logic [7:0] c;
      if ($urandom_range(9) == 0) begin
         c = 8'($urandom_range(255));
      end else begin
         c = 8'h80 + 8'($urandom_range(63));
      end
      return c;
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic eob);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{in_byte: b, end_of_buffer: eob};
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      items_sent++;
   endtask

   task automatic send_text(input int points);
      logic [7:0] text[$];
      int         kind;
      int         len;
      repeat (points) begin
         kind = $urandom_range(99);
         if (kind < 30) begin
            text.push_back(8'($urandom_range(127)));
         end else if (kind < 85) begin
            len = $urandom_range(4, 2);
            text.push_back(random_lead(len));
            repeat (len - 1) text.push_back(random_cont());
         end else if (kind < 93) begin
            text.push_back(8'($urandom_range(255)));
         end else begin
            len = $urandom_range(4, 2);
            text.push_back(random_lead(len));
            repeat ($urandom_range(len - 2)) text.push_back(random_cont());
         end
      end
      // Some buffers end inside a sequence.
      if ($urandom_range(2) == 0) begin
         len = $urandom_range(4, 2);
         text.push_back(random_lead(len));
         repeat ($urandom_range(len - 2)) text.push_back(random_cont());
      end
      foreach (text[i]) begin
         send_byte(text[i], i == text.size() - 1);
      end
   endtask

   initial begin : receiver
      bit stalled;
      stalled = 1'b0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off && !stalled) begin
            stalled = 1'b1;
            rsp_ready <= 1'b0;
            repeat (160) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   initial begin : stimulus
      int unsigned phase_start;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      recv_idle <= 0;
      hold_off <= 1'b0;
      send_idle = 0;
      items_sent = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      send_idle = 11;
      recv_idle <= 72;
      foreach (directed[i]) begin
         send_byte(directed[i][7:0], directed[i][8]);
      end
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle = 11;
               recv_idle <= 72;
            end
            1: begin
               send_idle = 72;
               recv_idle <= 11;
            end
            default: begin
               send_idle = 0;
               recv_idle <= 0;
               hold_off <= 1'b1;
            end
         endcase
         phase_start = items_sent;
         while (items_sent - phase_start < 80) begin
            send_text($urandom_range(6, 1));
         end
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("utf8_stream_decoder regression: pass");
      end else begin
         $display("utf8_stream_decoder regression: fail");
      end
      $finish;
   end

endmodule
